// ----- hdl/sta_pkg.sv -----
// Package for the sigmoid / tanh activation unit: widths, the breakpoint tables
// built at elaboration, and the control word carried down the pipeline.
// Depends on nothing.
package sta_pkg;

  // Number of equal segments over |x| in [0, 8]
  localparam int SEGMENTS = 64;

  // Segment index holds 0 .. SEGMENTS
  localparam int IDX_W = $clog2(SEGMENTS + 1);
  // |x| * SEGMENTS / 8: 15 fraction bits above which sits the index
  localparam int POS_W = 15 + IDX_W;
  // Unsigned Q0.30 magnitudes up to and including 1.0
  localparam int TAB_W = 31;

  localparam logic [TAB_W-1:0] ONE_Q30 = TAB_W'(1) << 30;

  // Output limits in Q1.14
  localparam logic [15:0] Q14_ONE = 16'd16384;

  // Activation codes of the configuration register
  localparam logic ACT_SIGMOID = 1'b0;
  localparam logic ACT_TANH    = 1'b1;

  // Segment width 8/SEGMENTS in Q0.30
  localparam longint EXP_Z = (longint'(8) <<< 30) / SEGMENTS;

  typedef logic [SEGMENTS:0][TAB_W-1:0] tab_t;

  // Control word that travels with every sample
  typedef struct packed {
    logic neg;    // sample was negative
    logic deriv;  // derivative wanted
    logic sel;    // activation code
    logic last;   // end of vector
  } ctrl_t;

  // Shift-and-subtract quotient for the table build, non-negative operands
  function automatic longint cdiv(input longint num, input longint dvs);
    longint quo;
    longint rem;
    int     b;
    quo = 0;
    rem = 0;
    for (b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      if (rem >= dvs) begin
        rem = rem - dvs;
        quo = quo | (longint'(1) <<< b);
      end
    end
    return quo;
  endfunction

  // Breakpoints from exp(-8/SEGMENTS) by Taylor series, evaluated at elaboration
  function automatic tab_t build_tab(input logic want_tanh);
    longint exp_v [2*SEGMENTS+1];
    tab_t   tab;
    longint one;
    longint term;
    longint sum;
    longint r;
    longint e;
    longint den;
    longint val;
    int     n;
    int     k;
    one  = longint'(1) <<< 30;
    term = one;
    sum  = one;
    for (n = 1; n <= 24; n++) begin
      term = cdiv((term * EXP_Z) >>> 30, longint'(n));
      if ((n & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    r = sum;
    exp_v[0] = one;
    for (k = 1; k <= 2 * SEGMENTS; k++) begin
      exp_v[k] = (exp_v[k-1] * r + (longint'(1) <<< 29)) >>> 30;
    end
    for (k = 0; k <= SEGMENTS; k++) begin
      if (want_tanh) begin
        e   = exp_v[2*k];
        den = one + e;
        val = cdiv((one - e) * one + (den >>> 1), den);
      end else begin
        e   = exp_v[k];
        den = one + e;
        val = cdiv((longint'(1) <<< 60) + (den >>> 1), den);
      end
      tab[k] = TAB_W'(val);
    end
    return tab;
  endfunction

  localparam tab_t SIG_TAB  = build_tab(1'b0);
  localparam tab_t TANH_TAB = build_tab(1'b1);

endpackage

// ----- hdl/sigmoid_tanh_activation_unit.sv -----
// Sigmoid / tanh activation unit with derivative, five-stage pipeline.
// Depends on sta_pkg (tables, widths, control word).
//
// Usage:
//   Input channel in_valid / in_ready carries one word: in_x (signed Q4.12),
//   in_kind (0 value, 1 derivative) and in_last_in. The result channel
//   out_valid / out_ready returns out_y (signed Q1.14, 16384 = 1.0) and
//   out_last_out, one result per word, in order.
//   cfg_valid / cfg_ready writes cfg_act_select (0 sigmoid, 1 tanh); cfg_ready
//   is always high. Write it only while no word is in flight.
//   Each word passes in order through the table lookup, the interpolation
//   multiply, the interpolation add, the derivative multiply and the output
//   rounding stages; out_valid is the last stage's valid bit. Throughput: one
//   word per cycle while the receiver does not stall.
//   Reset (rst_n low, synchronous) empties the pipeline and selects sigmoid.
//   When the receiver stalls, a stage holds only if the one after it is full
//   and held, so empty slots close up and in_ready drops once all five
//   stages are full.
module sigmoid_tanh_activation_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_x,
  input  logic               in_kind,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_y,
  output logic               out_last_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_act_select
);
  import sta_pkg::*;

  // Configuration register
  logic act_select_r;

  // Stage valid bits and enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  // Stage payloads
  ctrl_t              c1_r, c2_r, c3_r, c4_r, c5_r;
  logic [TAB_W-1:0]   lo1_r, lo2_r;
  logic signed [31:0] diff1_r;
  logic [14:0]        frac1_r;
  logic signed [47:0] prod2_r;
  logic [TAB_W-1:0]   f3_r, f4_r;
  logic [TAB_W-1:0]   ph4_r;
  logic signed [15:0] y5_r;

  // Stage 1 combinational: magnitude, segment and table lookup
  logic [16:0]        mag;
  logic [POS_W-1:0]   pos;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_hi;
  logic               sat;
  logic [TAB_W-1:0]   lo_nxt;
  logic [TAB_W-1:0]   hi_nxt;
  logic signed [31:0] diff_nxt;
  ctrl_t              c_in;

  // Later stages combinational
  logic signed [47:0] prod_nxt;
  logic signed [47:0] prod_adj;
  logic signed [31:0] f_sum;
  logic [TAB_W-1:0]   mul_b;
  logic [2*TAB_W-1:0] sq_nxt;
  logic [TAB_W-1:0]   m;
  logic [TAB_W:0]     m_rnd;
  logic [15:0]        q;
  logic [15:0]        q_sat;
  logic signed [15:0] y_nxt;

  // Handshake: a stage loads when empty or when the next one moves
  assign en5       = !v5_r || out_ready;
  assign en4       = !v4_r || en5;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_ready  = en1;
  assign cfg_ready = 1'b1;

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_select_r <= ACT_SIGMOID;
    end else if (cfg_valid && cfg_ready) begin
      act_select_r <= cfg_act_select;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: |x|, segment index and fraction, neighbouring breakpoints
  always_comb begin
    mag    = in_x[15] ? (17'h10000 - {1'b0, in_x}) : {1'b0, in_x};
    pos    = POS_W'(mag) * POS_W'(SEGMENTS);
    idx    = pos[POS_W-1:15];
    sat    = (idx >= IDX_W'(SEGMENTS));
    idx_hi = sat ? idx : idx + IDX_W'(1);
    if (act_select_r == ACT_TANH) begin
      lo_nxt = TANH_TAB[idx];
      hi_nxt = TANH_TAB[idx_hi];
    end else begin
      lo_nxt = SIG_TAB[idx];
      hi_nxt = SIG_TAB[idx_hi];
    end
    diff_nxt   = $signed({1'b0, hi_nxt}) - $signed({1'b0, lo_nxt});
    c_in.neg   = in_x[15];
    c_in.deriv = in_kind;
    c_in.sel   = act_select_r;
    c_in.last  = in_last_in;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      c1_r    <= c_in;
      lo1_r   <= lo_nxt;
      diff1_r <= diff_nxt;
      frac1_r <= pos[14:0];
    end
  end

  // Stage 2: slope times fraction
  assign prod_nxt = diff1_r * $signed({1'b0, frac1_r});

  always_ff @(posedge clk) begin
    if (en2) begin
      c2_r    <= c1_r;
      lo2_r   <= lo1_r;
      prod2_r <= prod_nxt;
    end
  end

  // Stage 3: add the scaled slope, truncating toward zero
  always_comb begin
    prod_adj = (prod2_r < 0) ? prod2_r + 48'sd32767 : prod2_r;
    f_sum    = $signed({1'b0, lo2_r}) + 32'(prod_adj >>> 15);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      c3_r <= c2_r;
      f3_r <= f_sum[TAB_W-1:0];
    end
  end

  // Stage 4: derivative product, s*(1-s) or t*t
  always_comb begin
    mul_b  = (c3_r.sel == ACT_TANH) ? f3_r : ONE_Q30 - f3_r;
    sq_nxt = f3_r * mul_b;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      c4_r  <= c3_r;
      f4_r  <= f3_r;
      ph4_r <= sq_nxt[30+TAB_W-1:30];
    end
  end

  // Stage 5: pick the magnitude, round to Q1.14, clamp and sign
  always_comb begin
    if (c4_r.sel == ACT_TANH) begin
      m = c4_r.deriv ? ONE_Q30 - ph4_r : f4_r;
    end else if (c4_r.deriv) begin
      m = ph4_r;
    end else begin
      m = c4_r.neg ? ONE_Q30 - f4_r : f4_r;
    end
    m_rnd = {1'b0, m} + (TAB_W+1)'(32768);
    q     = 16'(m_rnd >> 16);
    q_sat = (q > Q14_ONE) ? Q14_ONE : q;
    if (c4_r.sel == ACT_TANH && !c4_r.deriv && c4_r.neg) begin
      y_nxt = -$signed(q_sat);
    end else begin
      y_nxt = $signed(q_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      c5_r <= c4_r;
      y5_r <= y_nxt;
    end
  end

  assign out_valid    = v5_r;
  assign out_y        = y5_r;
  assign out_last_out = c5_r.last;

`ifndef SYNTHESIS
  // Results stay within plus and minus one
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_y >= -16'sd16384 && out_y <= 16'sd16384))
    else $error("result outside Q1.14 unit range");

  // Derivatives are never negative
  a_deriv_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && c5_r.deriv) |-> !out_y[15])
    else $error("negative derivative");

  // Input back-pressure only comes from a stalled, full output
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output stall");

  // A held fourth stage keeps its product and its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !en4) |=> (v4_r && $stable(ph4_r) && $stable(f4_r)))
    else $error("stalled stage lost its word");
`endif

endmodule
